### rtl/durs_pkg.sv
`default_nettype none

package durs_pkg;

  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUIET_AFTER_END         = 3'd0,
    CFG_QUIET_AFTER_START       = 3'd1,
    CFG_QUIET_AFTER_OTHER_START = 3'd2,
    CFG_ECHO_TIMEOUT            = 3'd3,
    CFG_PRIMARY_SENSOR          = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] QUIET_AFTER_END_RST         = CFG_W'(10 * 1000);
  localparam logic [CFG_W-1:0] QUIET_AFTER_START_RST       = CFG_W'(35 * 1000);
  localparam logic [CFG_W-1:0] QUIET_AFTER_OTHER_START_RST = CFG_W'(30 * 1000);
  localparam logic [CFG_W-1:0] ECHO_TIMEOUT_RST            = CFG_W'(75000);

endpackage

`default_nettype wire

### rtl/dual_ultrasonic_ranging_scheduler_unit.sv
`default_nettype none

// Scheduler for two ultrasonic echo sensors.
// Input channel (in_*): one item per microsecond tick carrying the timestamp
// and the echo-edge flag of each sensor. Output channel (out_*): exactly one
// item per input item, carrying an optional measurement report and an
// optional trigger request for the sensor to fire next.
// Configuration (cfg_*): write quiet times, echo timeout and primary sensor
// while no item is in progress; out-of-range indexes are ignored.
// An accepted item's result appears on the output register in the
// next cycle. Throughput: one item per clock while out_tready does not stall;
// the whole tick update is one pass of compare and select logic from the
// state registers into the result register.
// A new item is taken when no result is held or the held one is taken in the
// same cycle, so a stall on out_tready back-pressures in_tready one for one.
// Reset (rst_n low, synchronous) clears all stamps, flags and configuration
// to defaults; the first item after reset triggers the primary sensor and
// reports nothing.

module dual_ultrasonic_ranging_scheduler_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // now_us[31:0], echo_edge_a, echo_edge_b, zero pad
  input  wire logic [durs_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // report_valid, report_sensor, trigger_time[31:0], echo_rise_time[31:0],
  // echo_fall_time[31:0], timed_out, fire_valid, fire_sensor, zero pad
  output logic [durs_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [durs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [durs_pkg::CFG_W-1:0]        cfg_data
);

  import durs_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  typedef logic [TIME_BITS-1:0] stamp_t;

  logic [CFG_W-1:0] quiet_end_r, quiet_start_r, quiet_other_r, timeout_r;
  logic             primary_r;

  stamp_t     trig_r [2];
  stamp_t     rise_r [2];
  stamp_t     fall_r [2];
  logic [1:0] in_flight_r, rise_seen_r;
  logic       active_r, running_r, reported_r;

  stamp_t     trig_nxt [2];
  stamp_t     rise_nxt [2];
  stamp_t     fall_nxt [2];
  logic [1:0] in_flight_nxt, rise_seen_nxt;
  logic       active_nxt, running_nxt, reported_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  stamp_t     now;
  logic [1:0] edge_in;
  stamp_t     el_trig [2];
  stamp_t     el_fall [2];
  logic [1:0] trig_over, fall_over, start_over, other_over, timed, ready;
  logic       accept, a, prim, done, do_fire, fire_s;
  logic       rep_valid, rep_sensor, rep_to;
  logic [STAMP_W-1:0] rep_trig, rep_rise, rep_fall;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign now        = TIME_BITS'(in_tdata[STAMP_W-1:0]);
  assign edge_in[0] = in_tdata[STAMP_W];
  assign edge_in[1] = in_tdata[STAMP_W+1];
  assign a          = active_r;
  assign prim       = primary_r;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      trig_nxt[s] = trig_r[s];
      rise_nxt[s] = rise_r[s];
      fall_nxt[s] = fall_r[s];
    end
    in_flight_nxt = in_flight_r;
    rise_seen_nxt = rise_seen_r;
    active_nxt    = active_r;
    running_nxt   = running_r;
    reported_nxt  = reported_r;

    // take echo edges first
    for (int s = 0; s < 2; s++) begin
      if (in_flight_r[s] && edge_in[s]) begin
        if (!rise_seen_r[s]) begin
          rise_nxt[s]      = now;
          rise_seen_nxt[s] = 1'b1;
        end else begin
          fall_nxt[s]      = now;
          in_flight_nxt[s] = 1'b0;
        end
      end
    end

    for (int s = 0; s < 2; s++) begin
      el_trig[s]    = now - trig_r[s];
      el_fall[s]    = now - fall_nxt[s];
      trig_over[s]  = CMP_W'(el_trig[s]) > CMP_W'(timeout_r);
      fall_over[s]  = CMP_W'(el_fall[s]) > CMP_W'(quiet_end_r);
      start_over[s] = CMP_W'(el_trig[s]) > CMP_W'(quiet_start_r);
      timed[s]      = trig_over[s];
    end
    other_over[0] = CMP_W'(el_trig[1]) > CMP_W'(quiet_other_r);
    other_over[1] = CMP_W'(el_trig[0]) > CMP_W'(quiet_other_r);
    for (int s = 0; s < 2; s++) begin
      ready[s] = in_flight_nxt[s] ? timed[s]
                                  : (fall_over[s] && start_over[s] && other_over[s]);
    end

    rep_valid  = 1'b0;
    rep_sensor = 1'b0;
    rep_trig   = '0;
    rep_rise   = '0;
    rep_fall   = '0;
    rep_to     = 1'b0;
    do_fire    = 1'b0;
    fire_s     = 1'b0;
    done       = !in_flight_nxt[a] || timed[a];

    if (!running_r) begin
      running_nxt = 1'b1;
      do_fire     = 1'b1;
      fire_s      = prim;
    end else if (done) begin
      if (!reported_r) begin
        reported_nxt = 1'b1;
        rep_valid    = 1'b1;
        rep_sensor   = a;
        rep_trig     = STAMP_W'(trig_r[a]);
        rep_rise     = rise_seen_nxt[a] ? STAMP_W'(rise_nxt[a]) : '0;
        rep_fall     = in_flight_nxt[a] ? '0 : STAMP_W'(fall_nxt[a]);
        rep_to       = in_flight_nxt[a];
      end
      if (a == prim && ready[~prim]) begin
        do_fire = 1'b1;
        fire_s  = ~prim;
      end else if (ready[prim]) begin
        do_fire = 1'b1;
        fire_s  = prim;
      end
    end

    if (do_fire) begin
      trig_nxt[fire_s]      = now;
      rise_nxt[fire_s]      = '0;
      fall_nxt[fire_s]      = '0;
      rise_seen_nxt[fire_s] = 1'b0;
      in_flight_nxt[fire_s] = 1'b1;
      active_nxt            = fire_s;
      reported_nxt          = 1'b0;
    end

    out_data_nxt = OUT_TDATA_W'({fire_s, do_fire, rep_to, rep_fall, rep_rise, rep_trig,
                                 rep_sensor, rep_valid});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_end_r   <= QUIET_AFTER_END_RST;
      quiet_start_r <= QUIET_AFTER_START_RST;
      quiet_other_r <= QUIET_AFTER_OTHER_START_RST;
      timeout_r     <= ECHO_TIMEOUT_RST;
      primary_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUIET_AFTER_END:         quiet_end_r   <= cfg_data;
        CFG_QUIET_AFTER_START:       quiet_start_r <= cfg_data;
        CFG_QUIET_AFTER_OTHER_START: quiet_other_r <= cfg_data;
        CFG_ECHO_TIMEOUT:            timeout_r     <= cfg_data;
        CFG_PRIMARY_SENSOR:          primary_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        trig_r[s] <= '0;
        rise_r[s] <= '0;
        fall_r[s] <= '0;
      end
      in_flight_r <= '0;
      rise_seen_r <= '0;
      active_r    <= 1'b0;
      running_r   <= 1'b0;
      reported_r  <= 1'b0;
    end else if (accept) begin
      for (int s = 0; s < 2; s++) begin
        trig_r[s] <= trig_nxt[s];
        rise_r[s] <= rise_nxt[s];
        fall_r[s] <= fall_nxt[s];
      end
      in_flight_r <= in_flight_nxt;
      rise_seen_r <= rise_seen_nxt;
      active_r    <= active_nxt;
      running_r   <= running_nxt;
      reported_r  <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

### test/tb_dual_ultrasonic_ranging_scheduler_unit.sv
`default_nettype none

module tb_dual_ultrasonic_ranging_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import durs_pkg::*;

  typedef struct packed {
    logic [OUT_TDATA_W-102:0] pad;
    logic                     fire_sensor;
    logic                     fire_valid;
    logic                     timed_out;
    logic [STAMP_W-1:0]       echo_fall_time;
    logic [STAMP_W-1:0]       echo_rise_time;
    logic [STAMP_W-1:0]       trigger_time;
    logic                     report_sensor;
    logic                     report_valid;
  } report_t;

  typedef struct packed {
    logic [STAMP_W-1:0] now;
    logic               ea;
    logic               eb;
    logic               typed;
    report_t            want;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  dual_ultrasonic_ranging_scheduler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // scheduler state mirror
  logic [STAMP_W-1:0] trig_stamp [2];
  logic [STAMP_W-1:0] rise_t [2];
  logic [STAMP_W-1:0] fall_t [2];
  bit                 flying [2];
  bit                 rose [2];
  bit                 act_sensor;
  bit                 started;
  bit                 done_report;
  logic [CFG_W-1:0]   q_end = QUIET_AFTER_END_RST;
  logic [CFG_W-1:0]   q_start = QUIET_AFTER_START_RST;
  logic [CFG_W-1:0]   q_other = QUIET_AFTER_OTHER_START_RST;
  logic [CFG_W-1:0]   echo_limit = ECHO_TIMEOUT_RST;
  bit                 prim_sensor;

  report_t   report_q [$];
  tick_row_t dir_tab [$];
  int        mismatch_cnt;
  int        burst_left;
  int        sink_mode;
  int        sink_cnt;
  int        sink_left;
  report_t   got_rep;
  report_t   want_rep;

  initial begin
    for (int s = 0; s < 2; s++) begin
      trig_stamp[s] = '0;
      rise_t[s] = '0;
      fall_t[s] = '0;
      flying[s] = 1'b0;
      rose[s] = 1'b0;
    end
  end

  function automatic report_t mk_report(bit rv, bit rs, logic [31:0] tt, logic [31:0] rt,
                                        logic [31:0] ft, bit to, bit fv, bit fs);
    report_t r;
    r = '0;
    r.report_valid = rv;
    r.report_sensor = rs;
    r.trigger_time = tt;
    r.echo_rise_time = rt;
    r.echo_fall_time = ft;
    r.timed_out = to;
    r.fire_valid = fv;
    r.fire_sensor = fs;
    return r;
  endfunction

  function automatic bit sensor_free(bit s, logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] since_trig, since_fall, since_other;
    since_trig = now - trig_stamp[s];
    since_fall = now - fall_t[s];
    since_other = now - trig_stamp[!s];
    if (flying[s]) return since_trig > STAMP_W'(echo_limit);
    return since_fall > STAMP_W'(q_end) && since_trig > STAMP_W'(q_start)
        && since_other > STAMP_W'(q_other);
  endfunction

  function automatic void launch(bit s, logic [STAMP_W-1:0] now);
    trig_stamp[s] = now;
    rise_t[s] = '0;
    fall_t[s] = '0;
    rose[s] = 1'b0;
    flying[s] = 1'b1;
    act_sensor = s;
    done_report = 1'b0;
  endfunction

  function automatic report_t schedule_tick(logic [STAMP_W-1:0] now, bit ea, bit eb);
    report_t            r;
    bit                 eg [2];
    bit                 a, p;
    logic [STAMP_W-1:0] since;
    r = '0;
    eg[0] = ea;
    eg[1] = eb;
    p = prim_sensor;
    for (int s = 0; s < 2; s++) begin
      if (flying[s] && eg[s]) begin
        if (!rose[s]) begin
          rise_t[s] = now;
          rose[s] = 1'b1;
        end else begin
          fall_t[s] = now;
          flying[s] = 1'b0;
        end
      end
    end
    if (!started) begin
      started = 1'b1;
      launch(p, now);
      r.fire_valid = 1'b1;
      r.fire_sensor = p;
      return r;
    end
    a = act_sensor;
    since = now - trig_stamp[a];
    if (!flying[a] || since > STAMP_W'(echo_limit)) begin
      if (!done_report) begin
        done_report = 1'b1;
        r.report_valid = 1'b1;
        r.report_sensor = a;
        r.trigger_time = trig_stamp[a];
        r.echo_rise_time = rose[a] ? rise_t[a] : '0;
        r.echo_fall_time = flying[a] ? '0 : fall_t[a];
        r.timed_out = flying[a];
      end
      if (a == p && sensor_free(!p, now)) begin
        launch(!p, now);
        r.fire_valid = 1'b1;
        r.fire_sensor = !p;
      end else if (sensor_free(p, now)) begin
        launch(p, now);
        r.fire_valid = 1'b1;
        r.fire_sensor = p;
      end
    end
    return r;
  endfunction

  task automatic send_tick(input logic [STAMP_W-1:0] now, input bit ea, input bit eb,
                           input bit typed, input report_t want);
    int gap;
    report_t guess;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = 150;
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-34){1'b0}}, eb, ea, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = schedule_tick(now, ea, eb);
    report_q.push_back(typed ? want : guess);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] qe, input logic [CFG_W-1:0] qs,
                            input logic [CFG_W-1:0] qo, input logic [CFG_W-1:0] to,
                            input bit pr);
    cfg_we <= 1'b1;
    cfg_index <= CFG_QUIET_AFTER_END;
    cfg_data <= qe;
    @(posedge clk);
    cfg_index <= CFG_QUIET_AFTER_START;
    cfg_data <= qs;
    @(posedge clk);
    cfg_index <= CFG_QUIET_AFTER_OTHER_START;
    cfg_data <= qo;
    @(posedge clk);
    cfg_index <= CFG_ECHO_TIMEOUT;
    cfg_data <= to;
    @(posedge clk);
    cfg_index <= CFG_PRIMARY_SENSOR;
    cfg_data <= {(CFG_W-1)'($urandom_range(0, 32'h7FFFF)), pr};
    @(posedge clk);
    cfg_index <= CFG_IDX_W'(CFG_PRIMARY_SENSOR + 1 + $urandom_range(0, 2));
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    q_end = qe;
    q_start = qs;
    q_other = qo;
    echo_limit = to;
    prim_sensor = pr;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_rep = report_t'(out_tdata);
        if (report_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected output item: rv=%0d rs=%0d trig=%h rise=%h fall=%h to=%0d fv=%0d fs=%0d",
                     got_rep.report_valid, got_rep.report_sensor, got_rep.trigger_time,
                     got_rep.echo_rise_time, got_rep.echo_fall_time, got_rep.timed_out,
                     got_rep.fire_valid, got_rep.fire_sensor);
          mismatch_cnt++;
        end else begin
          want_rep = report_q.pop_front();
          if (got_rep.report_valid !== want_rep.report_valid
              || got_rep.report_sensor !== want_rep.report_sensor
              || got_rep.trigger_time !== want_rep.trigger_time
              || got_rep.echo_rise_time !== want_rep.echo_rise_time
              || got_rep.echo_fall_time !== want_rep.echo_fall_time
              || got_rep.timed_out !== want_rep.timed_out
              || got_rep.fire_valid !== want_rep.fire_valid
              || got_rep.fire_sensor !== want_rep.fire_sensor) begin
            if (mismatch_cnt < 10) begin
              $display("mismatch exp: rv=%0d rs=%0d trig=%h rise=%h fall=%h to=%0d fv=%0d fs=%0d",
                       want_rep.report_valid, want_rep.report_sensor, want_rep.trigger_time,
                       want_rep.echo_rise_time, want_rep.echo_fall_time, want_rep.timed_out,
                       want_rep.fire_valid, want_rep.fire_sensor);
              $display("         got: rv=%0d rs=%0d trig=%h rise=%h fall=%h to=%0d fv=%0d fs=%0d",
                       got_rep.report_valid, got_rep.report_sensor, got_rep.trigger_time,
                       got_rep.echo_rise_time, got_rep.echo_fall_time, got_rep.timed_out,
                       got_rep.fire_valid, got_rep.fire_sensor);
            end
            mismatch_cnt++;
          end
        end
      end
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 3);
        sink_left = $urandom_range(50, 300);
      end
      sink_left--;
      sink_cnt++;
      case (sink_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 99) >= 35);
        2: out_tready <= ((sink_cnt % 5) >= 2);
        default: out_tready <= ($urandom_range(0, 99) >= 70);
      endcase
    end
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                 stepmax, pct, pause_at, mx;
    logic [CFG_W-1:0]   v0, v1, v2, v3;
    bit                 pr;
    logic [STAMP_W-1:0] now;
    bit                 ea, eb;
    report_t            none;

    none = '0;
    dir_tab.push_back('{32'd0, 1'b1, 1'b1, 1'b1, mk_report(0, 0, 0, 0, 0, 0, 1, 0)});
    dir_tab.push_back('{32'd100, 1'b1, 1'b0, 1'b1, none});
    dir_tab.push_back('{32'd200, 1'b1, 1'b0, 1'b1, mk_report(1, 0, 0, 100, 200, 0, 0, 0)});
    dir_tab.push_back('{32'd300, 1'b0, 1'b1, 1'b1, none});
    dir_tab.push_back('{32'd40000, 1'b0, 1'b0, 1'b1, mk_report(0, 0, 0, 0, 0, 0, 1, 1)});
    dir_tab.push_back('{32'd40050, 1'b0, 1'b1, 1'b1, none});
    dir_tab.push_back('{32'd115051, 1'b0, 1'b0, 1'b1,
                        mk_report(1, 1, 40000, 40050, 0, 1, 1, 0)});
    dir_tab.push_back('{32'd115060, 1'b0, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'd115070, 1'b1, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'd190070, 1'b0, 1'b0, 1'b0, none});
    dir_tab.push_back('{32'd190071, 1'b0, 1'b0, 1'b0, none});
    dir_tab.push_back('{32'd190072, 1'b0, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'h0000_0005, 1'b1, 1'b0, 1'b0, none});
    dir_tab.push_back('{32'h0000_2000, 1'b0, 1'b0, 1'b0, none});
    dir_tab.push_back('{32'h8000_0000, 1'b1, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'h8000_0001, 1'b1, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'h8000_0001, 1'b1, 1'b1, 1'b0, none});
    dir_tab.push_back('{32'h8001_0000, 1'b0, 1'b0, 1'b0, none});
    dir_tab.push_back('{32'hAAAA_5555, 1'b1, 1'b0, 1'b0, none});
    dir_tab.push_back('{32'h5555_AAAA, 1'b0, 1'b1, 1'b0, none});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_tick(dir_tab[i].now, dir_tab[i].ea, dir_tab[i].eb, dir_tab[i].typed, dir_tab[i].want);
    now = 32'h5555_AAAA;

    for (int ph = 0; ph < 9; ph++) begin
      hold_until_drained();
      pr = 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          v0 = QUIET_AFTER_END_RST;
          v1 = QUIET_AFTER_START_RST;
          v2 = QUIET_AFTER_OTHER_START_RST;
          v3 = ECHO_TIMEOUT_RST;
          pr = 1'b0;
          stepmax = 30000;
          pct = 25;
        end
        1: begin
          v0 = '0;
          v1 = '0;
          v2 = '0;
          v3 = '0;
          pr = 1'b1;
          stepmax = 3;
          pct = 30;
          now = 32'hFFFF_FF00;
        end
        2, 3: begin
          v0 = '1;
          v1 = '1;
          v2 = '1;
          v3 = '1;
          pr = (ph == 3);
          stepmax = 800000;
          pct = (ph == 3) ? 35 : 20;
        end
        default: begin
          if (ph % 2 == 1) begin
            v0 = CFG_W'($urandom_range(0, 60));
            v1 = CFG_W'($urandom_range(0, 60));
            v2 = CFG_W'($urandom_range(0, 60));
            v3 = CFG_W'($urandom_range(0, 60));
          end else begin
            v0 = CFG_W'($urandom_range(0, 32'hFFFFF));
            v1 = CFG_W'($urandom_range(0, 32'hFFFFF));
            v2 = CFG_W'($urandom_range(0, 32'hFFFFF));
            v3 = CFG_W'($urandom_range(0, 32'hFFFFF));
          end
          mx = int'(v0);
          if (int'(v1) > mx) mx = int'(v1);
          if (int'(v2) > mx) mx = int'(v2);
          if (int'(v3) > mx) mx = int'(v3);
          stepmax = mx / 3 + 2;
          pct = $urandom_range(10, 40);
        end
      endcase
      write_regs(v0, v1, v2, v3, pr);
      pause_at = $urandom_range(20, 180);
      for (int k = 0; k < 200; k++) begin
        if (k == pause_at)
          hold_until_drained();
        if ($urandom_range(0, 99) < 2)
          now = $urandom;
        else
          now = now + STAMP_W'($urandom_range(0, stepmax));
        ea = ($urandom_range(0, 99) < pct);
        eb = ($urandom_range(0, 99) < pct);
        send_tick(now, ea, eb, 1'b0, none);
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
